### rtl/line_follower_steering_controller_assert.svh
// Assertion macros shared by the line follower checker
`ifndef LINE_FOLLOWER_STEERING_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOWER_STEERING_CONTROLLER_ASSERT_SVH

// Same-cycle implication, off during reset
`define LFSC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfsc check failed");

// Next-cycle implication, off during reset
`define LFSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfsc check failed");

`endif

### rtl/lfsc_pkg.sv
// Shared types, constants and register indexes of the line follower controller
package lfsc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN_P          = 3'd0;
    localparam logic [2:0] CFG_GAIN_D          = 3'd1;
    localparam logic [2:0] CFG_NOMINAL_SPEED   = 3'd2;
    localparam logic [2:0] CFG_BALANCE_Q8      = 3'd3;
    localparam logic [2:0] CFG_RIGHT_TURN_MASK = 3'd4;
    localparam logic [2:0] CFG_TURN_SPEED_A    = 3'd5;
    localparam logic [2:0] CFG_TURN_SPEED_B    = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the registers
    localparam logic [5:0]  GAIN_P_RST          = 6'd15;
    localparam logic [5:0]  GAIN_D_RST          = 6'd5;
    localparam logic [7:0]  NOMINAL_SPEED_RST   = 8'd81;
    localparam logic [7:0]  BALANCE_Q8_RST      = 8'd223;
    localparam logic [15:0] RIGHT_TURN_MASK_RST = 16'h77E4;
    localparam logic [7:0]  TURN_SPEED_A_RST    = 8'd66;
    localparam logic [7:0]  TURN_SPEED_B_RST    = 8'd76;

    // Run modes as reported on mode_out
    typedef enum logic [1:0] {
        MODE_FOLLOW = 2'd0,
        MODE_RIGHT  = 2'd1,
        MODE_LEFT   = 2'd2
    } mode_t;

    // Line error codes, signed two-bit
    localparam logic signed [1:0] ERR_NONE  = 2'sd0;
    localparam logic signed [1:0] ERR_LEFT  = -2'sd1;
    localparam logic signed [1:0] ERR_RIGHT = 2'sd1;

    // Settings seen by the drive law
    typedef struct packed {
        logic [5:0] gain_p;
        logic [5:0] gain_d;
        logic [7:0] nominal_speed;
        logic [7:0] balance_q8;
    } pd_cfg_t;

endpackage

### rtl/lfsc_pd_drive.sv
// PD drive law for line following: two clamped motor drives from the line error
module lfsc_pd_drive (
    input  lfsc_pkg::pd_cfg_t   cfg,
    input  logic signed [1:0]   err,
    input  logic signed [1:0]   prev_err,
    output logic [7:0]          drive_a,
    output logic [7:0]          drive_b
);
    import lfsc_pkg::*;

    logic signed [2:0]  diff;
    logic signed [8:0]  p_term;
    logic signed [8:0]  d_term;
    logic signed [8:0]  pid;
    logic [15:0]        base_bal;
    logic signed [17:0] bal_pid;
    logic signed [17:0] sum_a;
    logic signed [17:0] sum_b;

    // Proportional term: error is -1, 0 or +1, so a select does it
    always_comb begin
        case (err)
            ERR_RIGHT: p_term = $signed({3'b000, cfg.gain_p});
            ERR_LEFT:  p_term = -$signed({3'b000, cfg.gain_p});
            default:   p_term = '0;
        endcase
    end

    // Derivative term: error difference lies in -2..2
    assign diff = {err[1], err} - {prev_err[1], prev_err};

    always_comb begin
        case (diff)
            3'sd1:   d_term = $signed({3'b000, cfg.gain_d});
            3'sd2:   d_term = $signed({2'b00, cfg.gain_d, 1'b0});
            -3'sd1:  d_term = -$signed({3'b000, cfg.gain_d});
            -3'sd2:  d_term = -$signed({2'b00, cfg.gain_d, 1'b0});
            default: d_term = '0;
        endcase
    end

    assign pid = p_term + d_term;

    // Scaled sums, both in 1/256 units
    assign base_bal = {8'd0, cfg.nominal_speed} * {8'd0, cfg.balance_q8};
    assign bal_pid  = 18'($signed({1'b0, cfg.balance_q8})) * 18'(pid);
    assign sum_a    = $signed({2'b00, base_bal}) + $signed({pid[8], pid, 8'b0});
    assign sum_b    = $signed({2'b00, cfg.nominal_speed, 8'b0}) - bal_pid;

    // Clamp to 0..255 after dropping the fraction
    always_comb begin
        if (sum_a[17]) begin
            drive_a = '0;
        end else if (sum_a[16]) begin
            drive_a = 8'hFF;
        end else begin
            drive_a = sum_a[15:8];
        end
        if (sum_b[17]) begin
            drive_b = '0;
        end else if (sum_b[16]) begin
            drive_b = 8'hFF;
        end else begin
            drive_b = sum_b[15:8];
        end
    end

endmodule

### rtl/line_follower_steering_controller.sv
// Line follower steering controller: one sensor word in, one drive word out.
// The result of each accepted word is registered in the result register.
// Throughput: one word per cycle unless stalled; the result register frees as it is taken.
// Sensor edge memories, mode and marker count update as each word is accepted.
// Reset (aresetn low, synchronous) restores the register defaults, following
// mode, a zero count and empty output; center memory resets to no line.
module line_follower_steering_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [lfsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // sensor words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_outer_a,
    input  logic                                s_inner_a,
    input  logic                                s_center,
    input  logic                                s_inner_b,
    input  logic                                s_outer_b,
    // drive words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_drive_a,
    output logic [7:0]                          m_drive_b,
    output logic [1:0]                          m_mode_out,
    output logic [7:0]                          m_marker_count
);
    import lfsc_pkg::*;

    // Configuration registers
    pd_cfg_t     pd_cfg_reg;
    logic [15:0] turn_mask_reg;
    logic [7:0]  turn_speed_a_reg;
    logic [7:0]  turn_speed_b_reg;

    // Controller state
    mode_t             mode_reg, mode_next;
    logic signed [1:0] prev_err_reg, prev_err_next;
    logic [7:0]        markers_reg, markers_next;
    logic              outer_a_last_reg;
    logic              outer_b_last_reg;
    logic              center_last_reg, center_last_next;

    // Result register
    logic       m_valid_reg;
    logic [7:0] drive_a_reg, drive_a_next;
    logic [7:0] drive_b_reg, drive_b_next;
    mode_t      mode_out_reg;
    logic [7:0] count_reg;

    logic              accept;
    logic signed [1:0] err;
    logic              fall_a, fall_b, fall_c;
    logic [7:0]        pd_drive_a, pd_drive_b;
    mode_t             mode_mid;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pd_cfg_reg.gain_p        <= GAIN_P_RST;
            pd_cfg_reg.gain_d        <= GAIN_D_RST;
            pd_cfg_reg.nominal_speed <= NOMINAL_SPEED_RST;
            pd_cfg_reg.balance_q8    <= BALANCE_Q8_RST;
            turn_mask_reg            <= RIGHT_TURN_MASK_RST;
            turn_speed_a_reg         <= TURN_SPEED_A_RST;
            turn_speed_b_reg         <= TURN_SPEED_B_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN_P:          pd_cfg_reg.gain_p        <= cfg_wdata[5:0];
                CFG_GAIN_D:          pd_cfg_reg.gain_d        <= cfg_wdata[5:0];
                CFG_NOMINAL_SPEED:   pd_cfg_reg.nominal_speed <= cfg_wdata[7:0];
                CFG_BALANCE_Q8:      pd_cfg_reg.balance_q8    <= cfg_wdata[7:0];
                CFG_RIGHT_TURN_MASK: turn_mask_reg            <= cfg_wdata;
                CFG_TURN_SPEED_A:    turn_speed_a_reg         <= cfg_wdata[7:0];
                CFG_TURN_SPEED_B:    turn_speed_b_reg         <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Line error: inner_b wins over inner_a
    always_comb begin
        if (!s_inner_b) begin
            err = ERR_RIGHT;
        end else if (!s_inner_a) begin
            err = ERR_LEFT;
        end else begin
            err = ERR_NONE;
        end
    end

    // Falling edges (sensor went onto the line)
    assign fall_a = outer_a_last_reg && !s_outer_a;
    assign fall_b = outer_b_last_reg && !s_outer_b;
    assign fall_c = center_last_reg && !s_center;

    lfsc_pd_drive u_pd_drive (
        .cfg      (pd_cfg_reg),
        .err      (err),
        .prev_err (prev_err_reg),
        .drive_a  (pd_drive_a),
        .drive_b  (pd_drive_b)
    );

    // Mode, marker count and drive for the current word
    always_comb begin
        mode_mid         = mode_reg;
        markers_next     = markers_reg;
        prev_err_next    = prev_err_reg;
        center_last_next = center_last_reg;
        drive_a_next     = '0;
        drive_b_next     = '0;

        // marker edge, then left edge, both only while following
        if (fall_a && mode_reg == MODE_FOLLOW) begin
            markers_next = markers_reg + 8'd1;
            if (markers_next[7:4] == 4'd0 && turn_mask_reg[markers_next[3:0]]) begin
                mode_mid = MODE_RIGHT;
            end
        end
        if (fall_b && mode_mid == MODE_FOLLOW) begin
            mode_mid = MODE_LEFT;
        end

        mode_next = mode_mid;
        if (mode_mid == MODE_FOLLOW) begin
            prev_err_next = err;
            drive_a_next  = pd_drive_a;
            drive_b_next  = pd_drive_b;
        end else begin
            if (mode_mid == MODE_RIGHT) begin
                drive_a_next = turn_speed_a_reg;
            end else begin
                drive_b_next = turn_speed_b_reg;
            end
            // center edge ends the turn; memory tracks only while turning
            center_last_next = s_center;
            if (fall_c) begin
                mode_next = MODE_FOLLOW;
            end
        end
    end

    // State update on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_FOLLOW;
            prev_err_reg     <= ERR_NONE;
            markers_reg      <= '0;
            outer_a_last_reg <= 1'b0;
            outer_b_last_reg <= 1'b0;
            center_last_reg  <= 1'b1;
        end else if (accept) begin
            mode_reg         <= mode_next;
            prev_err_reg     <= prev_err_next;
            markers_reg      <= markers_next;
            outer_a_last_reg <= s_outer_a;
            outer_b_last_reg <= s_outer_b;
            center_last_reg  <= center_last_next;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_a_reg  <= drive_a_next;
            drive_b_reg  <= drive_b_next;
            mode_out_reg <= mode_next;
            count_reg    <= markers_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive_a      = drive_a_reg;
    assign m_drive_b      = drive_b_reg;
    assign m_mode_out     = mode_out_reg;
    assign m_marker_count = count_reg;

endmodule

### rtl/lfsc_checker.sv
// Port-level checks of the line follower controller, bound to the top level
`include "line_follower_steering_controller_assert.svh"

module lfsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_drive_a,
    input logic [7:0] m_drive_b,
    input logic [1:0] m_mode_out,
    input logic [7:0] m_marker_count
);
    import lfsc_pkg::*;

    logic [25:0] m_word;

    assign m_word = {m_drive_a, m_drive_b, m_mode_out, m_marker_count};

    // a stalled result word holds still
`LFSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word))

    // an empty result register never blocks the input
`LFSC_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // a right turn drives motor a alone
`LFSC_ASSERT_IMPLY(a_right_turn_drive, aclk, aresetn, m_valid && m_mode_out == MODE_RIGHT, m_drive_b == 8'd0)

    // a left turn drives motor b alone
`LFSC_ASSERT_IMPLY(a_left_turn_drive, aclk, aresetn, m_valid && m_mode_out == MODE_LEFT, m_drive_a == 8'd0)

endmodule

bind line_follower_steering_controller lfsc_checker u_lfsc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_drive_a      (m_drive_a),
    .m_drive_b      (m_drive_b),
    .m_mode_out     (m_mode_out),
    .m_marker_count (m_marker_count)
);
